/* src/sact_pkg.sv */
// ----------------------------------------------------------------------------
// sact_pkg
// shared types and constants of the cache tag controller
// ----------------------------------------------------------------------------
package sact_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LAT_W  = 10;
  localparam int unsigned DLY_W  = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  // geometry: ways match the 2-bit way field, sets must be a power of two
  localparam int unsigned WAYS = 4;
  localparam int unsigned SETS = 64;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [1:0] {
    REPL_RANDOM = 2'd0,
    REPL_LRU    = 2'd1,
    REPL_FIFO   = 2'd2,
    REPL_ALT    = 2'd3
  } repl_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPLACE_MODE = 3'd0,
    CFG_WRITE_MODE   = 3'd1,
    CFG_LOOKUP_DLY   = 3'd2,
    CFG_REPLACE_DLY  = 3'd3,
    CFG_RD_HIT_DLY   = 3'd4,
    CFG_WR_HIT_DLY   = 3'd5,
    CFG_WB_DLY       = 3'd6,
    CFG_WT_DLY       = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       repl_sel;
    logic             wr_policy;
    logic [DLY_W-1:0] lkup_dly;
    logic [DLY_W-1:0] refill_dly;
    logic [DLY_W-1:0] read_hit_delay;
    logic [DLY_W-1:0] write_hit_delay;
    logic [DLY_W-1:0] wb_dly;
    logic [DLY_W-1:0] wt_dly;
  } cfg_t;

endpackage

/* src/sact_front.sv */
// ----------------------------------------------------------------------------
// sact_front
// accepts transactions, splits the address, queues them for the back end
// ----------------------------------------------------------------------------
module sact_front #(
  parameter int unsigned SET_W  = 6,
  parameter int unsigned TAG_W  = 22,
  parameter int unsigned OFF_W  = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      kind_i,
  input  logic [sact_pkg::ADDR_W-1:0] address_i,
  output logic                      q_valid_o,
  input  logic                      q_ready_i,
  output logic                      q_kind_o,
  output logic [SET_W-1:0]          q_set_o,
  output logic [TAG_W-1:0]          q_tag_o
);
  import sact_pkg::*;

  // two-entry queue
  logic [1:0]       vld_q, vld_d;
  logic [1:0]       kind_q;
  logic [SET_W-1:0] set_q [2];
  logic [TAG_W-1:0] tag_q [2];
  logic [SET_W-1:0] set_in;
  logic [TAG_W-1:0] tag_in;
  logic             push, pop;
  logic             push_hi;

  assign set_in = address_i[OFF_W +: SET_W];
  assign tag_in = TAG_W'(address_i >> (OFF_W + SET_W));

  assign in_ready_o = ~vld_q[1];
  assign push = in_valid_i & in_ready_o;
  assign pop  = vld_q[0] & q_ready_i;
  // new transaction lands in the second slot when the head stays occupied
  assign push_hi = push & (pop ? vld_q[1] : vld_q[0]);

  assign q_valid_o = vld_q[0];
  assign q_kind_o  = kind_q[0];
  assign q_set_o   = set_q[0];
  assign q_tag_o   = tag_q[0];

  always_comb begin
    vld_d = vld_q;
    if (pop) vld_d = {1'b0, vld_q[1]};
    if (push) begin
      if (vld_d[0]) vld_d[1] = 1'b1;
      else vld_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !push_hi) begin
      kind_q[0] <= kind_i;
      set_q[0]  <= set_in;
      tag_q[0]  <= tag_in;
    end else if (pop) begin
      kind_q[0] <= kind_q[1];
      set_q[0]  <= set_q[1];
      tag_q[0]  <= tag_q[1];
    end
    if (push_hi) begin
      kind_q[1] <= kind_i;
      set_q[1]  <= set_in;
      tag_q[1]  <= tag_in;
    end
  end

endmodule

/* src/sact_back.sv */
// ----------------------------------------------------------------------------
// sact_back
// clears the store, reads a set, decides hit or victim, writes the set back
// ----------------------------------------------------------------------------
module sact_back #(
  parameter int unsigned SET_W = 6,
  parameter int unsigned TAG_W = 22,
  parameter int unsigned OFF_W = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sact_pkg::cfg_t        cfg_i,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  logic                  q_kind_i,
  input  logic [SET_W-1:0]      q_set_i,
  input  logic [TAG_W-1:0]      q_tag_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  hit_o,
  output logic [1:0]            way_o,
  output logic                  writeback_needed_o,
  output logic [sact_pkg::ADDR_W-1:0] writeback_line_address_o,
  output logic                  writethrough_needed_o,
  output logic [sact_pkg::LAT_W-1:0]  latency_o
);
  import sact_pkg::*;

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned AGE_W = $clog2(WAYS + 1);
  localparam int unsigned ENT_W = TAG_W + 2 + AGE_W;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_e;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic [AGE_W-1:0] age;
  } ent_t;

  state_e               state_q, state_d;
  logic [SET_W-1:0]     clr_q;
  logic [SET_W-1:0]     set_q;
  logic [TAG_W-1:0]     tag_q;
  logic                 kind_q;
  logic [15:0]          lfsr_q;
  logic [WAYS*ENT_W-1:0] mem [SETS];
  logic [WAYS*ENT_W-1:0] rd_q;
  logic [WAYS*ENT_W-1:0] wr_data;
  ent_t                 ent [WAYS];
  ent_t                 nent [WAYS];
  logic                 hit;
  logic [WAY_W-1:0]     hway, vway, way;
  logic [AGE_W-1:0]     best;
  logic                 repl;
  logic                 wb;
  logic                 wt;
  logic [LAT_W-1:0]     lat;
  logic [ADDR_W-1:0]    wb_addr;
  logic                 out_valid_q;
  logic                 touch;

  assign q_ready_o = (state_q == ST_IDLE) & (~out_valid_q | out_ready_i);

  always_comb begin
    for (int i = 0; i < WAYS; i++) ent[i] = rd_q[i*ENT_W +: ENT_W];
  end

  always_comb begin
    hit = 1'b0;
    hway = '0;
    for (int i = WAYS-1; i >= 0; i--) begin
      if (ent[i].valid && ent[i].tag == tag_q) begin
        hit = 1'b1;
        hway = WAY_W'(i);
      end
    end
    vway = '0;
    best = AGE_W'(WAYS);
    unique case (repl_mode_e'(cfg_i.repl_sel))
      REPL_LRU: begin
        best = ent[0].age;
        for (int i = 1; i < WAYS; i++) begin
          if (ent[i].age < best) begin
            best = ent[i].age;
            vway = WAY_W'(i);
          end
        end
      end
      REPL_FIFO: begin
        for (int i = 0; i < WAYS; i++) if (ent[i].age == '0) vway = WAY_W'(i);
      end
      REPL_RANDOM, REPL_ALT: vway = WAY_W'(lfsr_q % WAYS);
      default: vway = '0;
    endcase
    way = hit ? hway : vway;
    repl = (cfg_i.repl_sel == REPL_RANDOM) | (cfg_i.repl_sel == REPL_ALT);
    touch = hit ? (cfg_i.repl_sel == REPL_LRU) : ~repl;
    wb = ~hit & cfg_i.wr_policy & ent[way].valid & ent[way].dirty;
    wt = kind_q & ~cfg_i.wr_policy;
    wb_addr = wb ? ADDR_W'(({ent[way].tag, set_q}) << OFF_W) : '0;
    lat = LAT_W'(cfg_i.lkup_dly);
    if (hit) lat = lat + LAT_W'(kind_q ? cfg_i.write_hit_delay : cfg_i.read_hit_delay);
    else lat = lat + LAT_W'(cfg_i.refill_dly);
    if (wb) lat = lat + LAT_W'(cfg_i.wb_dly);
    if (wt) lat = lat + LAT_W'(cfg_i.wt_dly);
    for (int i = 0; i < WAYS; i++) begin
      nent[i] = ent[i];
      if (touch && WAY_W'(i) == way) nent[i].age = AGE_W'(WAYS - 1);
      else if (touch && ent[i].age != '0) nent[i].age = ent[i].age - 1'b1;
    end
    if (hit) begin
      if (kind_q) nent[way].dirty = 1'b1;
    end else begin
      nent[way].tag = tag_q;
      nent[way].valid = 1'b1;
      nent[way].dirty = kind_q & cfg_i.wr_policy;
    end
    for (int i = 0; i < WAYS; i++) wr_data[i*ENT_W +: ENT_W] = nent[i];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == SET_W'(SETS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (q_valid_i && q_ready_o) state_d = ST_READ;
      ST_READ:  state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      lfsr_q <= LFSR_SEED;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == ST_WRITE) begin
        out_valid_q <= 1'b1;
        if (!hit && repl) lfsr_q <= lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) mem[clr_q] <= '0;
    else if (state_q == ST_WRITE) mem[set_q] <= wr_data;
    rd_q <= mem[set_q];
    if (q_valid_i && q_ready_o) begin
      set_q <= q_set_i;
      tag_q <= q_tag_i;
      kind_q <= q_kind_i;
    end
    if (state_q == ST_WRITE) begin
      hit_o <= hit;
      way_o <= 2'(way);
      writeback_needed_o <= wb;
      writeback_line_address_o <= wb_addr;
      writethrough_needed_o <= wt;
      latency_o <= lat;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/set_assoc_cache_tag_controller_core.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller_core
// tag lookup and replacement of a set-associative cache
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | sink      | in_valid_i/in_ready_o, kind_i, address_i
// out     | source    | out_valid_o/out_ready_i, hit_o .. latency_o
// cfg     | sink      | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i
// a transaction goes through the back end in steps: take from the queue, set read,
// then decide and set write; the result is registered in the write step.
// the front queue holds two.
// after reset a clearing pass walks all SETS sets, one a cycle, before the
// first transaction is taken. a full output stalls the back end.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_controller_core #(
  parameter int unsigned OFFSET_BITS = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sact_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sact_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      kind_i,
  input  logic [31:0]               address_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      hit_o,
  output logic [1:0]                way_o,
  output logic                      writeback_needed_o,
  output logic [31:0]               writeback_line_address_o,
  output logic                      writethrough_needed_o,
  output logic [9:0]                latency_o
);
  import sact_pkg::*;

  localparam int unsigned SET_W = $clog2(SETS);
  localparam int unsigned TAG_W = ADDR_W - OFFSET_BITS - SET_W;

  cfg_t             cfg_q;
  logic             q_valid, q_ready, q_kind;
  logic [SET_W-1:0] q_set;
  logic [TAG_W-1:0] q_tag;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{repl_sel: REPL_LRU, wr_policy: 1'b1, lkup_dly: 8'd1,
                 refill_dly: 8'd1, read_hit_delay: 8'd1, write_hit_delay: 8'd1,
                 wb_dly: 8'd1, wt_dly: 8'd1};
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_REPLACE_MODE: cfg_q.repl_sel <= cfg_data_i[1:0];
        CFG_WRITE_MODE:   cfg_q.wr_policy <= cfg_data_i[0];
        CFG_LOOKUP_DLY:   cfg_q.lkup_dly <= cfg_data_i;
        CFG_REPLACE_DLY:  cfg_q.refill_dly <= cfg_data_i;
        CFG_RD_HIT_DLY:   cfg_q.read_hit_delay <= cfg_data_i;
        CFG_WR_HIT_DLY:   cfg_q.write_hit_delay <= cfg_data_i;
        CFG_WB_DLY:       cfg_q.wb_dly <= cfg_data_i;
        CFG_WT_DLY:       cfg_q.wt_dly <= cfg_data_i;
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  sact_front #(.SET_W(SET_W), .TAG_W(TAG_W), .OFF_W(OFFSET_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .address_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_kind_o(q_kind),
    .q_set_o(q_set), .q_tag_o(q_tag)
  );

  sact_back #(.SET_W(SET_W), .TAG_W(TAG_W), .OFF_W(OFFSET_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_kind_i(q_kind),
    .q_set_i(q_set), .q_tag_i(q_tag),
    .out_valid_o, .out_ready_i, .hit_o, .way_o, .writeback_needed_o,
    .writeback_line_address_o, .writethrough_needed_o, .latency_o
  );

  a_hit_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !writeback_needed_o) else $error("wb on hit");
  a_wb_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !writeback_needed_o |-> writeback_line_address_o == '0)
    else $error("stray wb address");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(latency_o))
    else $error("result dropped");

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the cache tag controller: hit/miss, victim choice,
// dirty write-back and write-through flags and latency sums under all modes
// ----------------------------------------------------------------------------
module tb_top;
  import sact_pkg::*;

  localparam int unsigned NWAYS = 4;
  localparam int unsigned NSETS = 64;
  localparam int unsigned OFFS  = 4;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic       hit;
    logic [1:0] way;
    logic       wb;
    logic [31:0] wb_addr;
    logic       wt;
    logic [9:0] lat;
  } tag_result_t;

  class tag_scoreboard;
    logic [25:0] tags [NSETS][NWAYS];
    bit          vld  [NSETS][NWAYS];
    bit          drt  [NSETS][NWAYS];
    int unsigned age  [NSETS][NWAYS];
    logic [15:0] lfsr;
    cfg_t        cfg;
    tag_result_t pending[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned hits;
    int unsigned writebacks;

    function new();
      foreach (vld[s, w]) begin
        tags[s][w] = '0; vld[s][w] = 0; drt[s][w] = 0; age[s][w] = 0;
      end
      lfsr = LFSR_SEED;
      cfg = '{repl_sel: 2'd1, wr_policy: 1'b1, default: 8'd1};
      mismatches = 0; checked = 0; hits = 0; writebacks = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [7:0] d);
      case (idx)
        CFG_REPLACE_MODE: cfg.repl_sel = d[1:0];
        CFG_WRITE_MODE:   cfg.wr_policy = d[0];
        CFG_LOOKUP_DLY:   cfg.lkup_dly = d;
        CFG_REPLACE_DLY:  cfg.refill_dly = d;
        CFG_RD_HIT_DLY:   cfg.read_hit_delay = d;
        CFG_WR_HIT_DLY:   cfg.write_hit_delay = d;
        CFG_WB_DLY:       cfg.wb_dly = d;
        CFG_WT_DLY:       cfg.wt_dly = d;
        default: ;
      endcase
    endfunction

    function void age_touch(int unsigned s, int unsigned w);
      age[s][w] = NWAYS;
      for (int i = 0; i < NWAYS; i++) if (age[s][i] != 0) age[s][i]--;
    endfunction

    function int unsigned choose_victim(int unsigned s);
      int unsigned v;
      int unsigned best;
      v = 0;
      best = NWAYS + 1;
      if (cfg.repl_sel == REPL_LRU) begin
        for (int i = 0; i < NWAYS; i++)
          if (age[s][i] < best) begin best = age[s][i]; v = i; end
      end else if (cfg.repl_sel == REPL_FIFO) begin
        for (int i = 0; i < NWAYS; i++) if (age[s][i] == 0) v = i;
      end else begin
        v = lfsr % NWAYS;
        lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
      end
      return v;
    endfunction

    function void note_access(logic is_wr, logic [31:0] addr);
      tag_result_t r;
      logic [27:0] line;
      int unsigned s;
      logic [25:0] tg;
      int unsigned w;
      logic [63:0] base;
      line = 28'(addr >> OFFS);
      s = line % NSETS;
      tg = 26'(line / NSETS);
      r = '0;
      r.lat = 10'(cfg.lkup_dly);
      w = 0;
      for (int i = NWAYS - 1; i >= 0; i--)
        if (vld[s][i] && tags[s][i] == tg) begin r.hit = 1; w = i; end
      if (r.hit) begin
        if (cfg.repl_sel == REPL_LRU) age_touch(s, w);
        if (is_wr) begin
          r.lat += cfg.write_hit_delay;
          drt[s][w] = 1;
          if (!cfg.wr_policy) begin r.wt = 1; r.lat += cfg.wt_dly; end
        end else r.lat += cfg.read_hit_delay;
      end else begin
        r.lat += cfg.refill_dly;
        w = choose_victim(s);
        if (cfg.wr_policy && vld[s][w] && drt[s][w]) begin
          base = ((64'(tags[s][w]) * NSETS) + s) << OFFS;
          r.wb = 1;
          r.wb_addr = base[31:0];
          r.lat += cfg.wb_dly;
        end
        if (!cfg.wr_policy && is_wr) begin r.wt = 1; r.lat += cfg.wt_dly; end
        tags[s][w] = tg;
        vld[s][w] = 1;
        drt[s][w] = is_wr && cfg.wr_policy;
        if (cfg.repl_sel == REPL_LRU || cfg.repl_sel == REPL_FIFO) age_touch(s, w);
      end
      r.way = w[1:0];
      pending.push_back(r);
    endfunction

    function void check_result(tag_result_t act);
      tag_result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", act);
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (act.hit) hits++;
      if (act.wb) writebacks++;
      if (act !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch #%0d:", checked);
          $display("  exp hit=%0b way=%0d wb=%0b wba=%h wt=%0b lat=%0d",
                   exp_r.hit, exp_r.way, exp_r.wb, exp_r.wb_addr, exp_r.wt, exp_r.lat);
          $display("  got hit=%0b way=%0d wb=%0b wba=%h wt=%0b lat=%0d",
                   act.hit, act.way, act.wb, act.wb_addr, act.wt, act.lat);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        kind_i;
  logic [31:0] address_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        hit_o;
  logic [1:0]  way_o;
  logic        writeback_needed_o;
  logic [31:0] writeback_line_address_o;
  logic        writethrough_needed_o;
  logic [9:0]  latency_o;

  tag_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycles;
  int unsigned sent;

  set_assoc_cache_tag_controller_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("FAIL set_assoc_cache_tag_controller_core");
        $finish;
      end
    end
  end

  // receiver: random stalls, compares every accepted result transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result('{hit_o, way_o, writeback_needed_o, writeback_line_address_o,
                          writethrough_needed_o, latency_o});
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid stays high across a burst of writes, the caller drops it
  task automatic write_reg(cfg_idx_e idx, logic [7:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, d);
  endtask

  task automatic send_access(logic is_wr, logic [31:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= is_wr;
    address_i  <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_access(is_wr, addr);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // addresses concentrated on a few sets and tags so hits and evictions occur
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    a = $urandom();
    if ($urandom_range(9) < 8) begin
      a[9:4] = 6'($urandom_range(3));
      a[31:10] = 22'($urandom_range(7)) | ($urandom_range(1) ? 22'h3FFFF8 : 22'h0);
    end
    return a;
  endfunction

  task automatic random_phase(int unsigned n);
    for (int i = 0; i < n; i++) send_access(1'($urandom_range(1)), pick_addr());
    drain();
  endtask

  task automatic set_all(logic [1:0] rm, logic wm, logic [7:0] d0, logic [7:0] d1);
    write_reg(CFG_REPLACE_MODE, {6'd0, rm});
    write_reg(CFG_WRITE_MODE, {7'd0, wm});
    write_reg(CFG_LOOKUP_DLY, d0);
    write_reg(CFG_REPLACE_DLY, d1);
    write_reg(CFG_RD_HIT_DLY, d0);
    write_reg(CFG_WR_HIT_DLY, d1);
    write_reg(CFG_WB_DLY, d0);
    write_reg(CFG_WT_DLY, d1);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    sb = new();
    sent = 0;
    send_idle_pct = 17;
    recv_idle_pct = 56;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i = 1'b0;
    address_i = '0;
    out_ready_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset config, extremes, same set filled past its ways
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b1, 32'h0000_0000);
    send_access(1'b1, 32'hFFFF_FFFF);
    send_access(1'b0, 32'hFFFF_FFF0);
    for (int i = 0; i < 6; i++) send_access(1'b1, 32'(i) << 10);
    send_access(1'b0, 32'h0000_0000);
    drain();
    set_all(REPL_FIFO, 1'b0, 8'd255, 8'd255);
    for (int i = 0; i < 6; i++) send_access(i[0], (32'(i) << 10) | 32'h0000_0010);
    send_access(1'b1, 32'h0000_0010);
    drain();
    set_all(REPL_ALT, 1'b1, 8'd0, 8'd0);
    for (int i = 0; i < 6; i++) send_access(1'b1, (32'(i) << 10) | 32'h0000_0020);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin send_idle_pct = 56; recv_idle_pct = 17; end
      if (ph == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
      set_all(2'(ph % 4), ph[0] ^ ph[2], 8'($urandom_range(255)), 8'($urandom_range(255)));
      random_phase(225);
    end

    $display("covered %0d accesses, %0d results checked, %0d hits, %0d write-backs",
             sent, sb.checked, sb.hits, sb.writebacks);
    $display("all replacement modes, both write modes, delays from 0 to 255");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS set_assoc_cache_tag_controller_core");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("FAIL set_assoc_cache_tag_controller_core");
    end
    $finish;
  end

endmodule
